>>> src/qeps_pkg.sv
`timescale 1ns / 1ps

package qeps_pkg;

    // Parameter defaults for the top level
    localparam int POSITION_WIDTH_DEF  = 64;
    localparam int SPEED_FRAC_BITS_DEF = 8;
    localparam int TICK_WIDTH_DEF      = 40;

    // Fixed field widths
    localparam int OUT_POS_W  = 64;
    localparam int SPD_W      = 40;
    localparam int CFG16_W    = 16;
    localparam int RATE_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // Register reset values
    localparam logic [CFG16_W-1:0] PPR_RST  = 16'd7;
    localparam logic [CFG16_W-1:0] GEAR_RST = 16'd1;
    localparam logic               QUAD_RST = 1'b1;
    localparam logic [RATE_W-1:0]  RATE_RST = 30'd1000000;

    // Speed saturation limits
    localparam logic [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPR  = 2'd0,
        CFG_GEAR = 2'd1,
        CFG_QUAD = 2'd2,
        CFG_RATE = 2'd3
    } t_cfg_idx;

    // Item commands; code 3 has no meaning
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SPEED = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [0:0] {
        TOP_IDLE,
        TOP_CALC
    } t_top_state;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_MUL,
        ENG_DIV,
        ENG_DONE
    } t_eng_state;

    // Control from the top level to the speed engine
    typedef struct packed {
        logic start;
        logic ack;
    } t_eng_ctrl;

endpackage

>>> src/qeps_speed_div.sv
`timescale 1ns / 1ps

// Bit-serial speed engine: two shift-and-add multipliers build numerator
// and denominator, then a restoring divider produces one quotient bit per cycle.
module qeps_speed_div #(
    parameter int POSITION_WIDTH  = qeps_pkg::POSITION_WIDTH_DEF,
    parameter int SPEED_FRAC_BITS = qeps_pkg::SPEED_FRAC_BITS_DEF,
    parameter int TICK_WIDTH      = qeps_pkg::TICK_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qeps_pkg::t_eng_ctrl                i_ctrl,
    input  logic [POSITION_WIDTH-1:0]          i_count,
    input  logic [POSITION_WIDTH-1:0]          i_ref,
    input  logic [TICK_WIDTH-1:0]              i_ticks,
    input  logic [qeps_pkg::CFG16_W-1:0]       i_ppr,
    input  logic [qeps_pkg::CFG16_W-1:0]       i_gear,
    input  logic                               i_quad,
    input  logic [qeps_pkg::RATE_W-1:0]        i_tick_rate,
    output logic                               o_done,
    output logic [qeps_pkg::SPD_W-1:0]         o_speed
);

    localparam int K60_W     = qeps_pkg::RATE_W + 6;
    localparam int K_W       = K60_W + SPEED_FRAC_BITS;
    localparam int PG_W      = 2 * qeps_pkg::CFG16_W;
    localparam int CPR_W     = PG_W + 2;
    localparam int NUM_W     = POSITION_WIDTH + K_W;
    localparam int DEN_W     = CPR_W + TICK_WIDTH;
    localparam int MUL_STEPS = (K_W > CPR_W) ? K_W : CPR_W;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int SPD_W     = qeps_pkg::SPD_W;

    qeps_pkg::t_eng_state r_state, n_state;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_neg;
    logic [POSITION_WIDTH-1:0] r_mag;
    logic [NUM_W-1:0]          r_pn;
    logic [DEN_W-1:0]          r_pd;
    logic [DEN_W:0]            r_rem;

    logic [POSITION_WIDTH-1:0] delta, rdelta, mag;
    logic                      neg;
    logic [qeps_pkg::CFG16_W-1:0] ppr1, gear1;
    logic [PG_W-1:0]           pg;
    logic [CPR_W-1:0]          cpr;
    logic [K60_W-1:0]          k60;
    logic [K_W-1:0]            kval;

    logic [POSITION_WIDTH:0]   num_sum;
    logic [NUM_W-1:0]          num_shift;
    logic [TICK_WIDTH:0]       den_sum;
    logic [DEN_W-1:0]          den_shift;
    logic                      num_en, den_en;

    logic [DEN_W:0]            rem_sh;
    logic [DEN_W+1:0]          rem_diff;
    logic                      qbit;

    logic                      over;
    logic [SPD_W-1:0]          qlo;

    // Operand setup: magnitude of the count change, counts per rev, scale
    always_comb begin
        delta  = i_count - i_ref;
        rdelta = i_ref - i_count;
        neg    = delta[POSITION_WIDTH-1];
        mag    = neg ? rdelta : delta;
        ppr1   = (i_ppr == '0) ? qeps_pkg::CFG16_W'(1) : i_ppr;
        gear1  = (i_gear == '0) ? qeps_pkg::CFG16_W'(1) : i_gear;
        pg     = PG_W'(ppr1) * PG_W'(gear1);
        cpr    = i_quad ? {pg, 2'b00} : {1'b0, pg, 1'b0};
        // 60 * rate as 64 * rate - 4 * rate
        k60    = {i_tick_rate, 6'b0} - {4'b0, i_tick_rate, 2'b0};
        kval   = K_W'(k60) << SPEED_FRAC_BITS;
    end

    // Multiply steps: add multiplicand into the high half, shift right
    always_comb begin
        num_en    = r_cnt < CNT_W'(K_W);
        den_en    = r_cnt < CNT_W'(CPR_W);
        num_sum   = {1'b0, r_pn[NUM_W-1:K_W]} + {1'b0, r_mag};
        num_shift = r_pn[0] ? {num_sum, r_pn[K_W-1:1]} : {1'b0, r_pn[NUM_W-1:1]};
        den_sum   = {1'b0, r_pd[DEN_W-1:CPR_W]} + {1'b0, i_ticks};
        den_shift = r_pd[0] ? {den_sum, r_pd[CPR_W-1:1]} : {1'b0, r_pd[DEN_W-1:1]};
    end

    // Divide step: trial subtract of the denominator
    always_comb begin
        rem_sh   = {r_rem[DEN_W-1:0], r_pn[NUM_W-1]};
        rem_diff = {1'b0, rem_sh} - {2'b00, r_pd};
        qbit     = ~rem_diff[DEN_W+1];
    end

    // Saturate and apply sign
    always_comb begin
        over = |r_pn[NUM_W-1:SPD_W-1];
        qlo  = r_pn[SPD_W-1:0];
        if (over) begin
            o_speed = r_neg ? qeps_pkg::SPD_MIN : qeps_pkg::SPD_MAX;
        end else begin
            o_speed = r_neg ? (SPD_W'(0) - qlo) : qlo;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qeps_pkg::ENG_IDLE: begin
                if (i_ctrl.start) n_state = qeps_pkg::ENG_MUL;
            end
            qeps_pkg::ENG_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) n_state = qeps_pkg::ENG_DIV;
            end
            qeps_pkg::ENG_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) n_state = qeps_pkg::ENG_DONE;
            end
            qeps_pkg::ENG_DONE: begin
                if (i_ctrl.ack) n_state = qeps_pkg::ENG_IDLE;
            end
            default: n_state = qeps_pkg::ENG_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        case (r_state)
            qeps_pkg::ENG_DONE: o_done = 1'b1;
            default:            o_done = 1'b0;
        endcase
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qeps_pkg::ENG_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state == qeps_pkg::ENG_MUL || r_state == qeps_pkg::ENG_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Shift registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            qeps_pkg::ENG_IDLE: begin
                if (i_ctrl.start) begin
                    r_neg <= neg;
                    r_mag <= mag;
                    r_pn  <= NUM_W'(kval);
                    r_pd  <= DEN_W'(cpr);
                    r_rem <= '0;
                end
            end
            qeps_pkg::ENG_MUL: begin
                if (num_en) r_pn <= num_shift;
                if (den_en) r_pd <= den_shift;
            end
            qeps_pkg::ENG_DIV: begin
                r_rem <= qbit ? rem_diff[DEN_W:0] : rem_sh;
                r_pn  <= {r_pn[NUM_W-2:0], qbit};
            end
            default: begin
            end
        endcase
    end

endmodule

>>> src/quadrature_encoder_position_speed_unit.sv
`timescale 1ns / 1ps

// Quadrature encoder counter with output-shaft speed. Sample (cmd 0), clear
// (cmd 2) and unused commands load the result register in the cycle after
// acceptance, so the block takes one such item per clock while the result
// register drains. A speed request that computes a new value runs through a
// bit-serial engine: acceptance, then shift-and-add multiply steps, then
// restoring divide steps at one bit per cycle, then delivery once the result
// register has room. Input ready is low meanwhile. The first speed request
// after reset or clear, and one with no tick since the last, answer in the
// cycle after acceptance. Configuration writes are accepted every cycle and
// must only happen while the block is idle.
module quadrature_encoder_position_speed_unit #(
    parameter int POSITION_WIDTH  = qeps_pkg::POSITION_WIDTH_DEF,
    parameter int SPEED_FRAC_BITS = qeps_pkg::SPEED_FRAC_BITS_DEF,
    parameter int TICK_WIDTH      = qeps_pkg::TICK_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [qeps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qeps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic                                  i_enc_a,
    input  logic                                  i_enc_b,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [qeps_pkg::OUT_POS_W-1:0] o_position,
    output logic signed [qeps_pkg::SPD_W-1:0]     o_speed_q8,
    output logic                                  o_speed_fresh,
    output logic                                  o_seq_error
);

    localparam int SPD_W = qeps_pkg::SPD_W;

    // configuration
    logic [qeps_pkg::CFG16_W-1:0] r_ppr, r_gear;
    logic                         r_quad;
    logic [qeps_pkg::RATE_W-1:0]  r_rate;

    // counter state
    logic                      r_last_a, n_last_a, r_last_b, n_last_b;
    logic [POSITION_WIDTH-1:0] r_count, n_count, r_ref, n_ref;
    logic [TICK_WIDTH-1:0]     r_ticks, n_ticks;
    logic                      r_seeded, n_seeded;
    logic [SPD_W-1:0]          r_held, n_held;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic [POSITION_WIDTH-1:0] r_out_pos, n_out_pos;
    logic [SPD_W-1:0]          r_out_speed, n_out_speed;
    logic                      r_out_fresh, n_out_fresh;
    logic                      r_out_err, n_out_err;

    qeps_pkg::t_top_state r_state, n_state;
    qeps_pkg::t_eng_ctrl  eng_ctrl;
    logic                 eng_done;
    logic [SPD_W-1:0]     eng_speed;

    logic                      in_accept, out_room, load_out, calc_go;
    logic                      ach, bch, step_up, step_dn, seq_err;
    logic [POSITION_WIDTH-1:0] step_val, tick_count;
    logic [TICK_WIDTH-1:0]     tick_next;

    assign o_cfg_ready = 1'b1;
    assign out_room    = ~r_out_valid | i_out_ready;
    assign in_accept   = i_in_valid & o_in_ready;

    // Line decode for one sample
    always_comb begin
        ach     = i_enc_a ^ r_last_a;
        bch     = i_enc_b ^ r_last_b;
        step_up = 1'b0;
        step_dn = 1'b0;
        seq_err = 1'b0;
        if (r_quad) begin
            if (ach && bch) begin
                seq_err = 1'b1;
            end else if (ach) begin
                step_up = i_enc_a ^ i_enc_b;
                step_dn = ~(i_enc_a ^ i_enc_b);
            end else if (bch) begin
                step_up = ~(i_enc_a ^ i_enc_b);
                step_dn = i_enc_a ^ i_enc_b;
            end
        end else begin
            step_up = ach;
        end
        step_val   = step_up ? POSITION_WIDTH'(1) : (step_dn ? '1 : '0);
        tick_count = r_count + step_val;
        tick_next  = (r_ticks == '1) ? r_ticks : r_ticks + TICK_WIDTH'(1);
    end

    // Item handling and speed write-back
    always_comb begin
        n_count     = r_count;
        n_ref       = r_ref;
        n_ticks     = r_ticks;
        n_seeded    = r_seeded;
        n_held      = r_held;
        n_last_a    = r_last_a;
        n_last_b    = r_last_b;
        load_out    = 1'b0;
        calc_go     = 1'b0;
        n_out_pos   = r_count;
        n_out_speed = r_held;
        n_out_fresh = 1'b0;
        n_out_err   = 1'b0;
        if (in_accept) begin
            case (i_cmd)
                qeps_pkg::CMD_TICK: begin
                    load_out  = 1'b1;
                    n_count   = tick_count;
                    n_last_a  = i_enc_a;
                    n_last_b  = i_enc_b;
                    n_ticks   = tick_next;
                    n_out_pos = tick_count;
                    n_out_err = seq_err;
                end
                qeps_pkg::CMD_SPEED: begin
                    if (!r_seeded) begin
                        load_out    = 1'b1;
                        n_seeded    = 1'b1;
                        n_ref       = r_count;
                        n_ticks     = '0;
                        n_held      = '0;
                        n_out_speed = '0;
                        n_out_fresh = 1'b1;
                    end else if (r_ticks != '0) begin
                        calc_go = 1'b1;
                    end else begin
                        load_out = 1'b1;
                    end
                end
                qeps_pkg::CMD_CLEAR: begin
                    load_out  = 1'b1;
                    n_count   = '0;
                    n_ref     = '0;
                    n_ticks   = '0;
                    n_seeded  = 1'b0;
                    n_out_pos = '0;
                end
                default: begin
                    load_out = 1'b1;
                end
            endcase
        end else if (eng_ctrl.ack) begin
            load_out    = 1'b1;
            n_held      = eng_speed;
            n_ref       = r_count;
            n_ticks     = '0;
            n_out_speed = eng_speed;
            n_out_fresh = 1'b1;
        end
        n_out_valid = load_out | (r_out_valid & ~i_out_ready);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qeps_pkg::TOP_IDLE: begin
                if (calc_go) n_state = qeps_pkg::TOP_CALC;
            end
            qeps_pkg::TOP_CALC: begin
                if (eng_ctrl.ack) n_state = qeps_pkg::TOP_IDLE;
            end
            default: n_state = qeps_pkg::TOP_IDLE;
        endcase
    end

    // Handshake and engine control
    always_comb begin
        eng_ctrl.start = calc_go;
        case (r_state)
            qeps_pkg::TOP_IDLE: begin
                o_in_ready   = out_room;
                eng_ctrl.ack = 1'b0;
            end
            qeps_pkg::TOP_CALC: begin
                o_in_ready   = 1'b0;
                eng_ctrl.ack = eng_done & out_room;
            end
            default: begin
                o_in_ready   = 1'b0;
                eng_ctrl.ack = 1'b0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr  <= qeps_pkg::PPR_RST;
            r_gear <= qeps_pkg::GEAR_RST;
            r_quad <= qeps_pkg::QUAD_RST;
            r_rate <= qeps_pkg::RATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qeps_pkg::CFG_PPR:  r_ppr  <= i_cfg_data[qeps_pkg::CFG16_W-1:0];
                qeps_pkg::CFG_GEAR: r_gear <= i_cfg_data[qeps_pkg::CFG16_W-1:0];
                qeps_pkg::CFG_QUAD: r_quad <= i_cfg_data[0];
                qeps_pkg::CFG_RATE: r_rate <= i_cfg_data[qeps_pkg::RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Counter state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qeps_pkg::TOP_IDLE;
            r_last_a    <= 1'b0;
            r_last_b    <= 1'b0;
            r_count     <= '0;
            r_ref       <= '0;
            r_ticks     <= '0;
            r_seeded    <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_a    <= n_last_a;
            r_last_b    <= n_last_b;
            r_count     <= n_count;
            r_ref       <= n_ref;
            r_ticks     <= n_ticks;
            r_seeded    <= n_seeded;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pos   <= n_out_pos;
            r_out_speed <= n_out_speed;
            r_out_fresh <= n_out_fresh;
            r_out_err   <= n_out_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_position    = qeps_pkg::OUT_POS_W'($signed(r_out_pos));
    assign o_speed_q8    = $signed(r_out_speed);
    assign o_speed_fresh = r_out_fresh;
    assign o_seq_error   = r_out_err;

    qeps_speed_div #(
        .POSITION_WIDTH  (POSITION_WIDTH),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .TICK_WIDTH      (TICK_WIDTH)
    ) u_speed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (eng_ctrl),
        .i_count     (r_count),
        .i_ref       (r_ref),
        .i_ticks     (r_ticks),
        .i_ppr       (r_ppr),
        .i_gear      (r_gear),
        .i_quad      (r_quad),
        .i_tick_rate (r_rate),
        .o_done      (eng_done),
        .o_speed     (eng_speed)
    );

endmodule

>>> src/qeps_checker.sv
`timescale 1ns / 1ps

module qeps_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic [1:0]                            i_cmd,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [qeps_pkg::OUT_POS_W-1:0] o_position,
    input logic signed [qeps_pkg::SPD_W-1:0]     o_speed_q8,
    input logic                                  o_speed_fresh,
    input logic                                  o_seq_error
);

    logic in_xfer;
    assign in_xfer = i_in_valid & o_in_ready;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_position) && $stable(o_speed_q8))
        else $error("result changed while stalled");

    // Clear answers in the next cycle with a zero position
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_cmd == qeps_pkg::CMD_CLEAR |=>
            o_out_valid && o_position == '0 && !o_speed_fresh)
        else $error("clear result wrong");

    // A sample answers in the next cycle and never carries a fresh speed
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_cmd == qeps_pkg::CMD_TICK |=> o_out_valid && !o_speed_fresh)
        else $error("sample result wrong");

    // Only samples can flag a sequence error; a speed calculation leaves the
    // result channel empty, with stale payload, in the next cycle
    a_seq_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_cmd != qeps_pkg::CMD_TICK |=> !o_out_valid || !o_seq_error)
        else $error("sequence error on non-sample transfer");

endmodule

bind quadrature_encoder_position_speed_unit qeps_checker u_qeps_checker (.*);

>>> sim/qeps_result_checker.sv
`timescale 1ns / 1ps

// Observes the register, item and result channels of the encoder unit. Every
// item transfer is run through a local model of the counter and speed logic,
// and every result transfer is compared with the oldest prediction.
module qeps_result_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [qeps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qeps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic                                  i_enc_a,
    input  logic                                  i_enc_b,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [qeps_pkg::OUT_POS_W-1:0] i_position,
    input  logic signed [qeps_pkg::SPD_W-1:0]     i_speed_q8,
    input  logic                                  i_speed_fresh,
    input  logic                                  i_seq_error,
    output int                                    o_results_due,
    output int                                    o_mismatch_count
);

    localparam int POS_W  = qeps_pkg::OUT_POS_W;
    localparam int SPD_W  = qeps_pkg::SPD_W;
    localparam int C16_W  = qeps_pkg::CFG16_W;
    localparam int RATE_W = qeps_pkg::RATE_W;
    localparam int TICK_W = qeps_pkg::TICK_WIDTH_DEF;
    localparam int FRAC   = qeps_pkg::SPEED_FRAC_BITS_DEF;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [SPD_W-1:0] speed_q8;
        logic                    speed_fresh;
        logic                    seq_error;
    } t_encoder_result;

    t_encoder_result predicted_q[$];

    // Register copies
    logic [C16_W-1:0]  ppr;
    logic [C16_W-1:0]  gear;
    logic              quad_mode;
    logic [RATE_W-1:0] rate_hz;

    // Decoder and speed state
    logic              last_a;
    logic              last_b;
    logic [POS_W-1:0]  count;
    logic [POS_W-1:0]  ref_count;
    logic [TICK_W-1:0] ticks;
    logic              seeded;
    logic [SPD_W-1:0]  held_speed;
    int                mismatches = 0;

    // Output shaft rpm in Q.FRAC since the reference, truncated and clamped
    function automatic logic [SPD_W-1:0] shaft_speed();
        logic [POS_W-1:0] delta;
        logic [POS_W-1:0] mag;
        logic             neg;
        logic [127:0]     ppr_eff;
        logic [127:0]     gear_eff;
        logic [127:0]     divisor;
        logic [127:0]     scale;
        logic [127:0]     quot;
        delta    = count - ref_count;
        neg      = delta[POS_W-1];
        mag      = neg ? -delta : delta;
        ppr_eff  = (ppr == '0) ? 128'd1 : 128'(ppr);
        gear_eff = (gear == '0) ? 128'd1 : 128'(gear);
        divisor  = ppr_eff * gear_eff * (quad_mode ? 128'd4 : 128'd2) * 128'(ticks);
        scale    = (128'(rate_hz) * 128'd60) << FRAC;
        quot     = (128'(mag) * scale) / divisor;
        if (neg) begin
            if (quot >= 128'(qeps_pkg::SPD_MIN)) return qeps_pkg::SPD_MIN;
            return -quot[SPD_W-1:0];
        end
        if (quot > 128'(qeps_pkg::SPD_MAX)) return qeps_pkg::SPD_MAX;
        return quot[SPD_W-1:0];
    endfunction

    // Advance the model by one item and queue the result it gives
    task automatic predict_item(input logic [1:0] cmd, input logic a, input logic b);
        t_encoder_result  res;
        logic             a_moved;
        logic             b_moved;
        logic [POS_W-1:0] step;
        res.speed_q8    = held_speed;
        res.speed_fresh = 1'b0;
        res.seq_error   = 1'b0;
        step            = '0;
        case (cmd)
            qeps_pkg::CMD_TICK: begin
                a_moved = (a != last_a);
                b_moved = (b != last_b);
                if (quad_mode) begin
                    // A edge: up when rising with B low, flipped by B high.
                    // B edge: up when falling with A low, flipped by A high.
                    if (a_moved && b_moved) begin
                        res.seq_error = 1'b1;
                    end else if (a_moved) begin
                        step = (a ^ b) ? POS_W'(1) : {POS_W{1'b1}};
                    end else if (b_moved) begin
                        step = (a ^ b) ? {POS_W{1'b1}} : POS_W'(1);
                    end
                end else if (a_moved) begin
                    step = POS_W'(1);
                end
                count  = count + step;
                last_a = a;
                last_b = b;
                if (ticks != TICK_MAX) ticks = ticks + TICK_W'(1);
            end
            qeps_pkg::CMD_SPEED: begin
                if (!seeded) begin
                    // first request after reset or clear only seeds
                    seeded          = 1'b1;
                    ref_count       = count;
                    ticks           = '0;
                    held_speed      = '0;
                    res.speed_q8    = '0;
                    res.speed_fresh = 1'b1;
                end else if (ticks != '0) begin
                    held_speed      = shaft_speed();
                    res.speed_q8    = held_speed;
                    res.speed_fresh = 1'b1;
                    ref_count       = count;
                    ticks           = '0;
                end
            end
            qeps_pkg::CMD_CLEAR: begin
                count     = '0;
                ref_count = '0;
                ticks     = '0;
                seeded    = 1'b0;
            end
            default: ;
        endcase
        res.position = count;
        predicted_q.push_back(res);
    endtask

    // Compare one result transfer against the oldest prediction
    task automatic check_result();
        t_encoder_result want;
        if (predicted_q.size() == 0) begin
            $error("result with no prediction waiting: position %0d", i_position);
            mismatches++;
        end else begin
            want = predicted_q.pop_front();
            if (i_position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, i_position);
                mismatches++;
            end
            if (i_speed_q8 !== want.speed_q8) begin
                $error("speed_q8: expected %0d, got %0d", want.speed_q8, i_speed_q8);
                mismatches++;
            end
            if (i_speed_fresh !== want.speed_fresh) begin
                $error("speed_fresh: expected %0d, got %0d", want.speed_fresh, i_speed_fresh);
                mismatches++;
            end
            if (i_seq_error !== want.seq_error) begin
                $error("seq_error: expected %0d, got %0d", want.seq_error, i_seq_error);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ppr        = qeps_pkg::PPR_RST;
            gear       = qeps_pkg::GEAR_RST;
            quad_mode  = qeps_pkg::QUAD_RST;
            rate_hz    = qeps_pkg::RATE_RST;
            last_a     = 1'b0;
            last_b     = 1'b0;
            count      = '0;
            ref_count  = '0;
            ticks      = '0;
            seeded     = 1'b0;
            held_speed = '0;
            predicted_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    qeps_pkg::CFG_PPR:  ppr = i_cfg_data[C16_W-1:0];
                    qeps_pkg::CFG_GEAR: gear = i_cfg_data[C16_W-1:0];
                    qeps_pkg::CFG_QUAD: quad_mode = i_cfg_data[0];
                    qeps_pkg::CFG_RATE: rate_hz = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            // results leave before the item accepted on the same edge is queued
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) predict_item(i_cmd, i_enc_a, i_enc_b);
        end
        o_results_due    <= predicted_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

>>> sim/quadrature_encoder_position_speed_unit_test.sv
`timescale 1ns / 1ps

module quadrature_encoder_position_speed_unit_test;

    localparam int         CFG_IDX_W       = qeps_pkg::CFG_IDX_W;
    localparam int         CFG_DATA_W      = qeps_pkg::CFG_DATA_W;
    localparam int         CFG16_W         = qeps_pkg::CFG16_W;
    localparam int         RATE_W          = qeps_pkg::RATE_W;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         CYCLE_LIMIT     = 2_000_000;
    localparam int         ITEMS_PER_PHASE = 250;
    localparam int         RANDOM_PHASES   = 6;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_cmd;
    logic                    i_enc_a;
    logic                    i_enc_b;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [qeps_pkg::OUT_POS_W-1:0] o_position;
    logic signed [qeps_pkg::SPD_W-1:0]     o_speed_q8;
    logic                    o_speed_fresh;
    logic                    o_seq_error;

    int   results_due;
    int   mismatch_count;
    int   cycle_count = 0;
    // line levels of the last sample sent, and the walk direction
    logic enc_a_now;
    logic enc_b_now;
    int   dir;
    int   calm_left;

    quadrature_encoder_position_speed_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_enc_a       (i_enc_a),
        .i_enc_b       (i_enc_b),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_position    (o_position),
        .o_speed_q8    (o_speed_q8),
        .o_speed_fresh (o_speed_fresh),
        .o_seq_error   (o_seq_error)
    );

    qeps_result_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_enc_a          (i_enc_a),
        .i_enc_b          (i_enc_b),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_position       (o_position),
        .i_speed_q8       (o_speed_q8),
        .i_speed_fresh    (o_speed_fresh),
        .i_seq_error      (o_seq_error),
        .o_results_due    (results_due),
        .o_mismatch_count (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: ready runs broken by stalls, mostly short, some long,
    // with the odd long stretch of no stall at all
    initial begin
        int hold_len;
        int stall_len;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            hold_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                    : $urandom_range(1, 20);
            stall_len = $urandom_range(0, 9);
            if (stall_len == 0) stall_len = $urandom_range(10, 60);
            else if (stall_len < 4) stall_len = 0;
            else stall_len = $urandom_range(1, 3);
            i_out_ready <= 1'b1;
            repeat (hold_len) @(negedge i_clk);
            if (stall_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    // One item transfer; valid stays high afterwards unless a gap follows
    task automatic send_item(input logic [1:0] cmd, input logic a, input logic b);
        int gap;
        int r;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            r   = $urandom_range(0, 99);
            gap = (r < 55) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_enc_a    <= a;
        i_enc_b    <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == qeps_pkg::CMD_TICK) begin
            enc_a_now = a;
            enc_b_now = b;
        end
    endtask

    // Move the encoder by d quarter steps; 2 changes both lines at once
    task automatic step_encoder(input int d);
        int ph;
        ph = enc_a_now ? (enc_b_now ? 2 : 1) : (enc_b_now ? 3 : 0);
        ph = (ph + d + 4) % 4;
        send_item(qeps_pkg::CMD_TICK, ph == 1 || ph == 2, ph == 2 || ph == 3);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_due != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input qeps_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Load all four registers on an idle block; unused data bits are random
    task automatic configure(input logic [CFG16_W-1:0] ppr, input logic [CFG16_W-1:0] gear,
                             input logic quad, input logic [RATE_W-1:0] rate);
        logic [CFG_DATA_W-1:0] word;
        drain();
        word = CFG_DATA_W'($urandom);
        word[CFG16_W-1:0] = ppr;
        write_reg(qeps_pkg::CFG_PPR, word);
        word = CFG_DATA_W'($urandom);
        word[CFG16_W-1:0] = gear;
        write_reg(qeps_pkg::CFG_GEAR, word);
        word = CFG_DATA_W'($urandom);
        word[0] = quad;
        write_reg(qeps_pkg::CFG_QUAD, word);
        write_reg(qeps_pkg::CFG_RATE, rate);
    endtask

    // Random line level for non-sample items
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly a clean quadrature walk with random direction changes and holds;
    // speed requests, clears, unused codes and line noise mixed in
    task automatic run_random(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 199) == 0) drain();
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_item(qeps_pkg::CMD_SPEED, rand_bit(), rand_bit());
            end else if (r == 4) begin
                send_item(qeps_pkg::CMD_CLEAR, rand_bit(), rand_bit());
            end else if (r == 5) begin
                send_item(CMD_UNUSED, rand_bit(), rand_bit());
            end else if (r < 9) begin
                send_item(qeps_pkg::CMD_TICK, rand_bit(), rand_bit());
            end else begin
                if ($urandom_range(0, 19) == 0) dir = -dir;
                step_encoder(($urandom_range(0, 3) == 0) ? 0 : dir);
            end
        end
    endtask

    initial begin
        int ph;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = qeps_pkg::CFG_PPR;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_cmd       = qeps_pkg::CMD_TICK;
        i_enc_a     = 1'b0;
        i_enc_b     = 1'b0;
        enc_a_now   = 1'b0;
        enc_b_now   = 1'b0;
        dir         = 1;
        calm_left   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: seed, repeat with no tick, a full encoder cycle forward, half of one back
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b0);
        send_item(qeps_pkg::CMD_SPEED, 1'b1, 1'b1);
        repeat (4) step_encoder(1);
        repeat (2) step_encoder(-1);
        step_encoder(2);
        send_item(CMD_UNUSED, 1'b1, 1'b0);
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b1);
        send_item(qeps_pkg::CMD_CLEAR, 1'b1, 1'b1);
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b0);
        step_encoder(1);
        send_item(qeps_pkg::CMD_SPEED, 1'b1, 1'b0);

        // 2x at top tick rate: both lines moving counts, B alone does not,
        // and the speed clamps high
        configure(16'd1, 16'd1, 1'b0, 30'd1_000_000_000);
        send_item(qeps_pkg::CMD_TICK, 1'b0, 1'b1);
        send_item(qeps_pkg::CMD_TICK, 1'b0, 1'b0);
        send_item(qeps_pkg::CMD_TICK, 1'b1, 1'b0);
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b0);

        // 4x at the largest rate, one count down: clamps low
        configure(16'd1, 16'd1, 1'b1, 30'h3FFF_FFFF);
        send_item(qeps_pkg::CMD_TICK, 1'b0, 1'b0);
        send_item(qeps_pkg::CMD_SPEED, 1'b1, 1'b1);

        // zero pulses and gear act as one
        configure(16'd0, 16'd0, 1'b1, 30'd1000);
        step_encoder(1);
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b0);

        // zero tick rate at the largest pulse and gear settings
        configure(16'hFFFF, 16'hFFFF, 1'b0, 30'd0);
        step_encoder(1);
        send_item(qeps_pkg::CMD_SPEED, 1'b0, 1'b0);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: configure(16'hFFFF, 16'hFFFF, 1'b1, 30'h3FFF_FFFF);
                1: configure(16'd1, 16'd1, 1'b0, 30'd1);
                2: configure(16'd1, 16'd1, 1'b1, 30'd1_000_000_000);
                3: configure(16'd0, 16'd0, 1'b1,
                             RATE_W'($urandom_range(1, 1_000_000_000)));
                default: configure(CFG16_W'($urandom_range(1, 65535)),
                                   CFG16_W'($urandom_range(1, 300)),
                                   rand_bit(),
                                   RATE_W'($urandom_range(1, 1_000_000_000)));
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
